[sv/coordinate_keyed_lru_cache_core_macros.svh]
// Assertion macros used by the cache RTL.
`ifndef COORDINATE_KEYED_LRU_CACHE_CORE_MACROS_SVH
`define COORDINATE_KEYED_LRU_CACHE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CKL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache assertion failed");
`define CKL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache assertion failed");
`else
`define CKL_ASSERT_NOW(lbl, ante, cons)
`define CKL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/ckl_pkg.sv]
`default_nettype none
package ckl_pkg;

    localparam int KEY_W       = 32;
    localparam int SLOT_W      = 6;
    localparam int COUNT_W     = 7;
    localparam int CAP_W       = 7;
    localparam int CAP_MIN     = 16;
    localparam int CAP_RESET   = 64;
    localparam int ENTRIES_DEF = 64;

    // Broadcast from the lookup logic to every entry.
    typedef struct packed {
        logic step;
        logic clear;
        logic hit;
    } cell_cmd_t;

    // Per-entry status returned to the lookup logic.
    typedef struct packed {
        logic match;
        logic lru;
    } cell_stat_t;

endpackage
`default_nettype wire

[sv/ckl_ram.sv]
`default_nettype none
module ckl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: a read and a write at the same address return the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[sv/ckl_cell.sv]
`default_nettype none
module ckl_cell
    import ckl_pkg::*;
#(
    parameter int IDX_W = 6
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic signed [KEY_W-1:0] key_x,
    input  wire logic signed [KEY_W-1:0] key_y,
    input  wire cell_cmd_t               cmd,
    input  wire logic                    sel,
    input  wire logic [IDX_W-1:0]        hit_rank,
    input  wire logic [IDX_W-1:0]        lru_rank,
    output cell_stat_t                   stat,
    output logic [IDX_W-1:0]             rank
);

    logic                    valid_reg;
    logic                    valid_next;
    logic [IDX_W-1:0]        rank_reg;
    logic [IDX_W-1:0]        rank_next;
    logic signed [KEY_W-1:0] x_reg;
    logic signed [KEY_W-1:0] y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && !cmd.clear && sel && !cmd.hit)
        begin
            x_reg <= key_x;
            y_reg <= key_y;
        end
    end

    // On a hit only entries more recent than the hit entry age; on a miss all others do.
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
            rank_next  = '0;
        end
        else if (cmd.step)
        begin
            if (sel)
            begin
                rank_next = '0;
                if (!cmd.hit)
                begin
                    valid_next = 1'b1;
                end
            end
            else if (valid_reg && (!cmd.hit || (rank_reg < hit_rank)))
            begin
                rank_next = rank_reg + IDX_W'(1);
            end
        end
    end

    assign stat.match = valid_reg && (x_reg == key_x) && (y_reg == key_y);
    assign stat.lru   = valid_reg && (rank_reg == lru_rank);
    assign rank       = rank_reg;

endmodule
`default_nettype wire

[sv/coordinate_keyed_lru_cache_core.sv]
// Fully associative LRU cache keyed by a signed (x, y) pair. One lookup is
// accepted per cycle unless a result held by out_ready low blocks the input
// register; a lookup passes through the input register, then the result
// register, and the next lookup sees all state changes of the previous one.
// Throughput is set by the combinational match and the age update across all
// entry cells. Live entries always occupy the lowest slots, so a miss without
// eviction fills slot live_count, and the victim on a full miss is the entry
// whose age rank equals live_count - 1. Keys are also held in a RAM that
// supplies the evicted key. Writing capacity clears the cache; after reset
// the cache is empty and needs no clearing pass.
`default_nettype none
module coordinate_keyed_lru_cache_core
    import ckl_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [KEY_W-1:0] key_x,
    input  wire logic signed [KEY_W-1:0] key_y,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         hit,
    output logic [SLOT_W-1:0]            slot,
    output logic                         evicted,
    output logic signed [KEY_W-1:0]      evicted_x,
    output logic signed [KEY_W-1:0]      evicted_y,
    output logic [COUNT_W-1:0]           live_count,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CAP_W-1:0]        capacity
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CAP_INIT = (ENTRIES < CAP_RESET) ? ENTRIES : CAP_RESET;

    // Input stage
    logic                    s0_valid_reg;
    logic                    s0_valid_next;
    logic signed [KEY_W-1:0] kx_reg;
    logic signed [KEY_W-1:0] ky_reg;

    // Result stage
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    hit_reg;
    logic [IDX_W-1:0]        slot_reg;
    logic                    evicted_reg;
    logic [CNT_W-1:0]        live_reg;

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W-1:0]        cap_reg;
    logic [CNT_W-1:0]        cap_fit;
    logic [31:0]             cap_wide;

    logic                    adv0;
    logic                    cfg_write;
    logic                    lookup_hit;
    logic                    full;
    logic                    evict;
    logic                    fill;
    logic [IDX_W-1:0]        hit_idx;
    logic [IDX_W-1:0]        hit_rank;
    logic [IDX_W-1:0]        victim_idx;
    logic [IDX_W-1:0]        new_slot;
    logic [CNT_W-1:0]        count_m1;
    logic [IDX_W-1:0]        lru_rank;
    logic [ENTRIES-1:0]      match_vec;
    logic [ENTRIES-1:0]      sel_vec;
    cell_stat_t              stat [ENTRIES];
    logic [IDX_W-1:0]        ranks [ENTRIES];
    cell_cmd_t               cmd;
    logic [2*KEY_W-1:0]      ram_rdata;
    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [CNT_W+COUNT_W-1:0] live_ext;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign adv0      = s0_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s0_valid_reg || adv0;

    // Capacity is kept between the minimum and the number of entries.
    always_comb
    begin
        cap_wide = 32'(capacity);
        if (cap_wide < 32'(CAP_MIN))
        begin
            cap_fit = CNT_W'(CAP_MIN);
        end
        else if (cap_wide > 32'(ENTRIES))
        begin
            cap_fit = CNT_W'(ENTRIES);
        end
        else
        begin
            cap_fit = CNT_W'(capacity);
        end
    end

    // At most one entry matches and one entry holds the oldest rank, so the
    // one-hot vectors reduce to indexes with plain OR trees.
    always_comb
    begin
        hit_idx    = '0;
        hit_rank   = '0;
        victim_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (stat[i].match)
            begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | ranks[i];
            end
            if (stat[i].lru)
            begin
                victim_idx = victim_idx | IDX_W'(i);
            end
        end
    end

    assign lookup_hit = |match_vec;
    assign full       = count_reg >= cap_reg;
    assign evict      = !lookup_hit && full;
    assign fill       = adv0 && !lookup_hit && !evict;
    assign count_m1   = count_reg - CNT_W'(1);
    assign lru_rank   = count_m1[IDX_W-1:0];

    always_comb
    begin
        if (lookup_hit)
        begin
            new_slot = hit_idx;
        end
        else if (evict)
        begin
            new_slot = victim_idx;
        end
        else
        begin
            new_slot = count_reg[IDX_W-1:0];
        end
    end

    always_comb
    begin
        if (cfg_write)
        begin
            count_next = '0;
        end
        else if (fill)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    assign cmd.step  = adv0;
    assign cmd.clear = cfg_write;
    assign cmd.hit   = lookup_hit;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_entry
        assign sel_vec[g]   = (new_slot == IDX_W'(g));
        assign match_vec[g] = stat[g].match;

        ckl_cell #(
            .IDX_W    (IDX_W)
        ) u_entry (
            .clk      (clk),
            .rst_n    (rst_n),
            .key_x    (kx_reg),
            .key_y    (ky_reg),
            .cmd      (cmd),
            .sel      (sel_vec[g]),
            .hit_rank (hit_rank),
            .lru_rank (lru_rank),
            .stat     (stat[g]),
            .rank     (ranks[g])
        );
    end

    // Key copy for the eviction report; read-first returns the victim's key.
    ckl_ram #(
        .WIDTH (2 * KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (adv0 && !lookup_hit),
        .waddr (new_slot),
        .wdata ({kx_reg, ky_reg}),
        .re    (adv0),
        .raddr (victim_idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        if (in_valid && in_ready)
        begin
            s0_valid_next = 1'b1;
        end
        else if (adv0)
        begin
            s0_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv0)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            cap_reg       <= CNT_W'(CAP_INIT);
        end
        else
        begin
            s0_valid_reg  <= s0_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            if (cfg_write)
            begin
                cap_reg <= cap_fit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kx_reg <= key_x;
            ky_reg <= key_y;
        end
        if (adv0)
        begin
            hit_reg     <= lookup_hit;
            slot_reg    <= new_slot;
            evicted_reg <= evict;
            live_reg    <= (lookup_hit || evict) ? count_reg : count_reg + CNT_W'(1);
        end
    end

    assign slot_ext = {{SLOT_W{1'b0}}, slot_reg};
    assign live_ext = {{COUNT_W{1'b0}}, live_reg};

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign slot       = slot_ext[SLOT_W-1:0];
    assign evicted    = evicted_reg;
    assign evicted_x  = evicted_reg ? ram_rdata[2*KEY_W-1:KEY_W] : '0;
    assign evicted_y  = evicted_reg ? ram_rdata[KEY_W-1:0] : '0;
    assign live_count = live_ext[COUNT_W-1:0];

`include "coordinate_keyed_lru_cache_core_macros.svh"

    `CKL_ASSERT_NOW(a_count_in_cap, 1'b1, count_reg <= cap_reg)
    `CKL_ASSERT_NOW(a_single_match, s0_valid_reg, $onehot0(match_vec))
    `CKL_ASSERT_NOW(a_evict_when_full, s0_valid_reg && evict, count_reg == cap_reg)
    `CKL_ASSERT_NOW(a_victim_unique, s0_valid_reg && evict, $onehot(sel_vec))
    `CKL_ASSERT_NEXT(a_fill_grows, fill && !cfg_write, count_reg == $past(count_reg) + CNT_W'(1))

endmodule
`default_nettype wire

[dv/tb_coordinate_keyed_lru_cache_core.sv]
`timescale 1ns / 100ps
module tb_coordinate_keyed_lru_cache_core;
    import ckl_pkg::*;

    localparam int ENTRIES = ENTRIES_DEF;
    localparam int PHASES = 10;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic signed [KEY_W-1:0] x;
        logic signed [KEY_W-1:0] y;
    } key_pair_t;

    typedef struct packed {
        logic                    hit;
        logic [SLOT_W-1:0]       slot;
        logic                    evicted;
        logic signed [KEY_W-1:0] ex;
        logic signed [KEY_W-1:0] ey;
        logic [COUNT_W-1:0]      live;
    } lookup_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [KEY_W-1:0] key_x = '0;
    logic signed [KEY_W-1:0] key_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit;
    logic [SLOT_W-1:0] slot;
    logic evicted;
    logic signed [KEY_W-1:0] evicted_x;
    logic signed [KEY_W-1:0] evicted_y;
    logic [COUNT_W-1:0] live_count;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CAP_W-1:0] capacity = '0;

    // Shadow copy of the cache contents and its capacity setting.
    logic signed [KEY_W-1:0] shadow_x [ENTRIES];
    logic signed [KEY_W-1:0] shadow_y [ENTRIES];
    bit shadow_valid [ENTRIES];
    int unsigned shadow_rank [ENTRIES];
    int unsigned shadow_count = 0;
    int unsigned cap_limit = CAP_RESET;

    key_pair_t key_requests[$];
    lookup_result_t predicted_results[$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int stall_left = 0;
    int long_hold_left = 0;
    bit long_hold_done = 1'b0;
    bit long_hold_armed = 1'b0;
    bit calm = 1'b0;

    coordinate_keyed_lru_cache_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .key_x      (key_x),
        .key_y      (key_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .slot       (slot),
        .evicted    (evicted),
        .evicted_x  (evicted_x),
        .evicted_y  (evicted_y),
        .live_count (live_count),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .capacity   (capacity)
    );

    always #5 clk = ~clk;

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic lookup_result_t predict_lookup(logic signed [KEY_W-1:0] kx,
                                                      logic signed [KEY_W-1:0] ky);
        lookup_result_t r;
        bit found;
        bit have;
        int unsigned best;
        int idx;
        r = '0;
        found = 1'b0;
        have = 1'b0;
        best = 0;
        idx = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!found && shadow_valid[i] && shadow_x[i] == kx && shadow_y[i] == ky)
            begin
                found = 1'b1;
                idx = i;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            for (int i = 0; i < ENTRIES; i++)
                if (shadow_valid[i] && shadow_rank[i] < shadow_rank[idx])
                    shadow_rank[i]++;
            shadow_rank[idx] = 0;
        end
        else
        begin
            if (shadow_count >= cap_limit)
            begin
                // The victim is the valid entry with the highest age rank.
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (shadow_valid[i] && (!have || shadow_rank[i] > best))
                    begin
                        best = shadow_rank[i];
                        idx = i;
                        have = 1'b1;
                    end
                end
                if (have)
                begin
                    r.evicted = 1'b1;
                    r.ex = shadow_x[idx];
                    r.ey = shadow_y[idx];
                    shadow_valid[idx] = 1'b0;
                    shadow_count--;
                end
            end
            if (!r.evicted)
            begin
                found = 1'b0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!found && !shadow_valid[i])
                    begin
                        found = 1'b1;
                        idx = i;
                    end
                end
            end
            for (int i = 0; i < ENTRIES; i++)
                if (shadow_valid[i])
                    shadow_rank[i]++;
            shadow_x[idx] = kx;
            shadow_y[idx] = ky;
            shadow_valid[idx] = 1'b1;
            shadow_rank[idx] = 0;
            shadow_count++;
        end
        r.slot = SLOT_W'(idx);
        r.live = COUNT_W'(shadow_count);
        return r;
    endfunction

    function automatic logic signed [KEY_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return KEY_W'($urandom_range(0, 3)) - 2;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_key(logic signed [KEY_W-1:0] x, logic signed [KEY_W-1:0] y);
        key_pair_t k;
        k.x = x;
        k.y = y;
        key_requests.push_back(k);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (key_requests.size() != 0 || in_valid || predicted_results.size() != 0);
    endtask

    task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endtask

    // Request driver: holds a request until it is taken, otherwise idles in
    // bursts or offers the next queued key.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        key_pair_t next_key;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predicted_results.push_back(predict_lookup(key_x, key_y));
            if (in_valid && !in_ready)
            begin
                in_valid <= 1'b1;
            end
            else if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                in_valid <= 1'b0;
                send_gap <= $urandom_range(0, 14);
            end
            else if (key_requests.size() != 0)
            begin
                next_key = key_requests.pop_front();
                in_valid <= 1'b1;
                key_x <= next_key.x;
                key_y <= next_key.y;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        lookup_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
            long_hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual hit=%0b slot=%0d",
                             $time, hit, slot);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (hit !== want.hit)
                        report_mismatch("hit", want.hit, hit);
                    if (slot !== want.slot)
                        report_mismatch("slot", want.slot, slot);
                    if (evicted !== want.evicted)
                        report_mismatch("evicted", want.evicted, evicted);
                    if (evicted_x !== want.ex)
                        report_mismatch("evicted_x", want.ex, evicted_x);
                    if (evicted_y !== want.ey)
                        report_mismatch("evicted_y", want.ey, evicted_y);
                    if (live_count !== want.live)
                        report_mismatch("live_count", want.live, live_count);
                end
            end
            // One long hold-off lets the input side back up behind full results.
            if (long_hold_left != 0)
            begin
                out_ready <= 1'b0;
                long_hold_left <= long_hold_left - 1;
            end
            else if (long_hold_armed && !long_hold_done)
            begin
                out_ready <= 1'b0;
                long_hold_left <= LONG_HOLD_CYCLES;
                long_hold_done <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                out_ready <= 1'b0;
                stall_left <= $urandom_range(0, 14);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase_caps [PHASES];
        int phase_items [PHASES];
        key_pair_t pool[$];
        key_pair_t k;
        int cap_value;
        int pool_size;
        int pick;
        phase_caps = '{0, 16, 127, 5, 64, 17, 40, 100, -1, 16};
        phase_items = '{120, 120, 170, 120, 160, 120, 130, 160, 130, 80};
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_rank[i] = 0;
            shadow_x[i] = '0;
            shadow_y[i] = '0;
        end
        do
            @(negedge clk);
        while (!rst_n);

        // Corner keys with the reset capacity, then repeats that must hit and a final new key.
        push_key(KEY_MIN, KEY_MIN);
        push_key(KEY_MAX, KEY_MAX);
        push_key(KEY_MIN, KEY_MAX);
        push_key(KEY_MAX, KEY_MIN);
        push_key(0, 0);
        push_key(-1, -1);
        push_key(0, -1);
        push_key(-1, 0);
        push_key(1, 1);
        push_key(KEY_MIN, KEY_MIN);
        push_key(0, 0);
        push_key(KEY_MAX, KEY_MIN);
        push_key(-1, -1);
        push_key(1, 0);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            repeat (4) @(posedge clk);
            cap_value = (phase_caps[p] < 0) ? $urandom_range(0, 127) : phase_caps[p];
            cfg_valid <= 1'b1;
            capacity <= CAP_W'(cap_value);
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            cap_limit = (cap_value < CAP_MIN) ? CAP_MIN :
                        (cap_value > ENTRIES) ? ENTRIES : cap_value;
            for (int i = 0; i < ENTRIES; i++)
            begin
                shadow_valid[i] = 1'b0;
                shadow_rank[i] = 0;
            end
            shadow_count = 0;
            if (p == PHASES - 1)
                calm <= 1'b1;
            @(negedge clk);

            // A working set a little larger than the capacity gives a mix of
            // hits, fills and evictions; a share of keys is fresh or half-matching.
            pool.delete();
            pool_size = cap_limit + $urandom_range(2, cap_limit / 2);
            repeat (pool_size)
            begin
                k.x = rand_coord();
                k.y = rand_coord();
                pool.push_back(k);
            end
            repeat (phase_items[p])
            begin
                pick = $urandom_range(0, 99);
                k = pool[$urandom_range(0, pool.size() - 1)];
                if (pick >= 90)
                begin
                    k.x = rand_coord();
                    k.y = rand_coord();
                end
                else if (pick >= 85)
                    k.x = rand_coord();
                else if (pick >= 75)
                    k.y = rand_coord();
                key_requests.push_back(k);
            end
            if (p == 2)
                long_hold_armed = 1'b1;
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/ckl_pkg.sv
sv/ckl_ram.sv
sv/ckl_cell.sv
sv/coordinate_keyed_lru_cache_core.sv
dv/tb_coordinate_keyed_lru_cache_core.sv
